@@ hdl/afb_pkg.sv @@
// types, constants and register codes shared by the frame builder modules
package afb_pkg;

    localparam int LEN_W = 7;
    localparam int BURST_MAX = 10;
    localparam int CNT_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 7'd100;

    localparam logic [7:0] FRAME_DELIM = 8'h7E;
    localparam logic [7:0] TYPE_DATA = 8'h01;
    localparam logic [7:0] TYPE_CMD = 8'h08;
    localparam logic [15:0] DATA_HDR_LEN = 16'd5;
    localparam logic [15:0] CMD_HDR_LEN = 16'd4;

    typedef logic [7:0] byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_FRAME_ID = 2'd0,
        CFG_CMD_FRAME_ID  = 2'd1,
        CFG_DEST_ADDRESS  = 2'd2,
        CFG_TX_OPTIONS    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                 mode;
        byte_t                payload_byte;
        logic [LEN_W-1:0]     payload_len;
        byte_t                cmd_char_a;
        byte_t                cmd_char_b;
    } in_t;

    typedef struct packed {
        byte_t out_byte;
        logic  frame_done;
        logic  run_last;
    } out_t;

    typedef struct packed {
        byte_t       data_frame_id;
        byte_t       command_frame_id;
        logic [15:0] dest_address;
        byte_t       tx_options;
    } cfg_t;

    // bytes caused by one word, emitted from slot 0 upward
    typedef struct packed {
        byte_t [BURST_MAX-1:0] bytes;
        logic [CNT_W-1:0]      count;
        logic                  done;
    } burst_t;

endpackage

@@ hdl/afb_framer.sv @@
// frame state and construction of the byte burst for one input word
module afb_framer
    import afb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   accept,
    input  in_t    item,
    input  cfg_t   cfg,
    output burst_t burst
);

    logic             in_frame_reg, in_frame_next;
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    byte_t            sum_reg, sum_next;

    logic [LEN_W-1:0] len_sat;
    logic [15:0]      flen;
    byte_t            hdr_sum;
    byte_t            first_sum;
    byte_t            mid_sum;
    logic             mid_last;

    always_comb
    begin
        len_sat = (item.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : item.payload_len;
        flen = (item.mode ? CMD_HDR_LEN : DATA_HDR_LEN) + 16'(len_sat);
        if (item.mode)
        begin
            hdr_sum = TYPE_CMD + cfg.command_frame_id + item.cmd_char_a + item.cmd_char_b;
        end
        else
        begin
            hdr_sum = TYPE_DATA + cfg.data_frame_id + cfg.dest_address[15:8]
                    + cfg.dest_address[7:0] + cfg.tx_options;
        end
        first_sum = hdr_sum + item.payload_byte;
        mid_sum = sum_reg + item.payload_byte;
        mid_last = (bytes_left_reg <= LEN_W'(1));
    end

    // burst assembly
    always_comb
    begin
        burst = '0;
        if (!in_frame_reg)
        begin
            burst.bytes[0] = FRAME_DELIM;
            burst.bytes[1] = flen[15:8];
            burst.bytes[2] = flen[7:0];
            if (item.mode)
            begin
                burst.bytes[3] = TYPE_CMD;
                burst.bytes[4] = cfg.command_frame_id;
                burst.bytes[5] = item.cmd_char_a;
                burst.bytes[6] = item.cmd_char_b;
                if (len_sat == '0)
                begin
                    burst.bytes[7] = ~hdr_sum;
                    burst.count = CNT_W'(8);
                    burst.done = 1'b1;
                end
                else
                begin
                    burst.bytes[7] = item.payload_byte;
                    burst.bytes[8] = ~first_sum;
                    burst.done = (len_sat == LEN_W'(1));
                    burst.count = burst.done ? CNT_W'(9) : CNT_W'(8);
                end
            end
            else
            begin
                burst.bytes[3] = TYPE_DATA;
                burst.bytes[4] = cfg.data_frame_id;
                burst.bytes[5] = cfg.dest_address[15:8];
                burst.bytes[6] = cfg.dest_address[7:0];
                burst.bytes[7] = cfg.tx_options;
                if (len_sat == '0)
                begin
                    burst.bytes[8] = ~hdr_sum;
                    burst.count = CNT_W'(9);
                    burst.done = 1'b1;
                end
                else
                begin
                    burst.bytes[8] = item.payload_byte;
                    burst.bytes[9] = ~first_sum;
                    burst.done = (len_sat == LEN_W'(1));
                    burst.count = burst.done ? CNT_W'(10) : CNT_W'(9);
                end
            end
        end
        else
        begin
            burst.bytes[0] = item.payload_byte;
            burst.bytes[1] = ~mid_sum;
            burst.done = mid_last;
            burst.count = mid_last ? CNT_W'(2) : CNT_W'(1);
        end
    end

    // state update on an accepted word
    always_comb
    begin
        in_frame_next = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (len_sat == '0)
                begin
                    in_frame_next = 1'b0;
                    bytes_left_next = '0;
                    sum_next = hdr_sum;
                end
                else
                begin
                    bytes_left_next = len_sat - LEN_W'(1);
                    in_frame_next = (len_sat != LEN_W'(1));
                    sum_next = first_sum;
                end
            end
            else
            begin
                sum_next = mid_sum;
                in_frame_next = !mid_last;
                bytes_left_next = mid_last ? '0 : bytes_left_reg - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            bytes_left_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg <= sum_next;
        end
    end

endmodule

@@ hdl/afb_serializer.sv @@
// burst buffer and output register, one byte per cycle while result_stall does not hold the output
module afb_serializer
    import afb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  burst_t burst,
    output logic   ready,
    output logic   result_valid,
    input  logic   result_stall,
    output out_t   result
);

    byte_t [BURST_MAX-1:0] buf_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic                  done_reg;
    logic                  busy_reg;
    logic                  out_valid_reg;
    out_t                  out_reg;

    logic pop;
    logic last_pop;

    assign pop = busy_reg && (!out_valid_reg || !result_stall);
    assign last_pop = pop && (idx_reg == cnt_reg - CNT_W'(1));
    // the next burst may load while the last byte of this one moves out
    assign ready = !busy_reg || last_pop;

    assign result_valid = out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg <= '0;
            end
            else if (last_pop)
            begin
                busy_reg <= 1'b0;
            end
            else if (pop)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= burst.bytes;
            cnt_reg <= burst.count;
            done_reg <= burst.done;
        end
        if (pop)
        begin
            out_reg.out_byte <= buf_reg[idx_reg];
            out_reg.frame_done <= done_reg && last_pop;
            out_reg.run_last <= last_pop;
        end
    end

endmodule

@@ hdl/api_frame_builder_with_checksum.sv @@
// top level of the api frame builder: config registers, framer, serializer
// a taken word's burst is loaded into the serializer buffer; its bytes then pass through the output register
// throughput: one output byte per cycle while result_stall is low; a word causes
//   8 to 10 bytes on a frame start and 1 or 2 bytes mid-frame
// the next word is taken in the cycle its predecessor's last byte is registered
// reset: rst_n clears frame state, config registers and output valid asynchronously
module api_frame_builder_with_checksum
    import afb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input word channel
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_t                   item,
    // output word channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_t                  result,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t   cfg_reg;
    burst_t burst;
    logic   ready;
    logic   accept;

    // a word is taken only when the serializer can load its burst
    assign item_stall = !ready;
    assign accept = item_valid && ready;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_DATA_FRAME_ID: cfg_reg.data_frame_id <= cfg_wdata[7:0];
                CFG_CMD_FRAME_ID:  cfg_reg.command_frame_id <= cfg_wdata[7:0];
                CFG_DEST_ADDRESS:  cfg_reg.dest_address <= cfg_wdata;
                CFG_TX_OPTIONS:    cfg_reg.tx_options <= cfg_wdata[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // header, payload and checksum bytes for one word, plus frame state
    afb_framer u_framer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .burst  (burst)
    );

    // burst buffer drained into the output register
    afb_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .burst        (burst),
        .ready        (ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ test/tb.sv @@
// testbench for the api frame builder: framed byte stream and checksum against a predictor
`timescale 1ns / 1ps

module tb;
    import afb_pkg::*;

    // frame kinds carried in the mode field of the first word of a frame
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_CMD  = 1'b1;

    // worst case is far below this: about 500 words, each up to ten bytes,
    // every byte held off and every word delayed by at most MAX_GAP
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 13;
    localparam int PRINT_CAP   = 20;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    in_t               item;
    logic              result_valid;
    logic              result_stall;
    out_t              result;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // shadow of the register file and of the open frame
    cfg_t              shadow_cfg;
    logic              frame_open;
    logic              open_kind;
    logic [LEN_W-1:0]  bytes_left;
    byte_t             csum;

    // bytes the block still owes, oldest first
    out_t              frame_bytes[$];

    int                mismatch_count = 0;
    int                result_count = 0;
    int                words_sent = 0;
    int                cycle_count = 0;
    bit                gaps_on = 1'b1;

    // receiver hold-off, redrawn after each accepted byte
    bit                took_byte = 1'b0;
    int                sink_wait = 0;

    api_frame_builder_with_checksum uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch: %s", msg);
    endtask

    // works out every byte one accepted word causes and queues them in order
    task automatic predict_word(input in_t w);
        byte_t            seq [0:BURST_MAX-1];
        logic             fin [0:BURST_MAX-1];
        int               n;
        logic [LEN_W-1:0] len;
        logic [15:0]      flen;
        out_t             r;
        n = 0;
        for (int i = 0; i < BURST_MAX; i++)
            fin[i] = 1'b0;
        if (!frame_open)
        begin
            // first word of a frame: header, then maybe the first payload byte
            len = (w.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : w.payload_len;
            open_kind = w.mode;
            csum = 8'h00;
            flen = ((open_kind == MODE_CMD) ? CMD_HDR_LEN : DATA_HDR_LEN) + 16'(len);
            seq[0] = FRAME_DELIM;
            seq[1] = flen[15:8];
            seq[2] = flen[7:0];
            if (open_kind == MODE_DATA)
            begin
                seq[3] = TYPE_DATA;
                seq[4] = shadow_cfg.data_frame_id;
                seq[5] = shadow_cfg.dest_address[15:8];
                seq[6] = shadow_cfg.dest_address[7:0];
                seq[7] = shadow_cfg.tx_options;
                n = 8;
            end
            else
            begin
                seq[3] = TYPE_CMD;
                seq[4] = shadow_cfg.command_frame_id;
                seq[5] = w.cmd_char_a;
                seq[6] = w.cmd_char_b;
                n = 7;
            end
            // checksum covers the type byte onward
            for (int i = 3; i < n; i++)
                csum = csum + seq[i];
            bytes_left = '0;
            if (len != 0)
            begin
                seq[n] = w.payload_byte;
                csum = csum + w.payload_byte;
                n = n + 1;
                bytes_left = len - 1'b1;
            end
        end
        else
        begin
            // mid-frame: only the payload byte counts
            seq[n] = w.payload_byte;
            csum = csum + w.payload_byte;
            n = n + 1;
            if (bytes_left > 0)
                bytes_left = bytes_left - 1'b1;
        end
        // empty frame or last payload byte: checksum closes the frame
        if (bytes_left == 0)
        begin
            seq[n] = 8'hFF - csum;
            fin[n] = 1'b1;
            n = n + 1;
            frame_open = 1'b0;
        end
        else
            frame_open = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            r.out_byte = seq[i];
            r.frame_done = fin[i];
            r.run_last = (i == n - 1);
            frame_bytes.push_back(r);
        end
    endtask

    // offers one word after a random gap and waits until it is taken
    task automatic send_word(input in_t w);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_word(w);
        words_sent = words_sent + 1;
    endtask

    function automatic in_t make_word(input logic m, input byte_t pb,
                                      input logic [LEN_W-1:0] len,
                                      input byte_t a, input byte_t b);
        in_t w;
        w.mode = m;
        w.payload_byte = pb;
        w.payload_len = len;
        w.cmd_char_a = a;
        w.cmd_char_b = b;
        return w;
    endfunction

    // only called while the block is idle
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            CFG_DATA_FRAME_ID: shadow_cfg.data_frame_id = val[7:0];
            CFG_CMD_FRAME_ID:  shadow_cfg.command_frame_id = val[7:0];
            CFG_DEST_ADDRESS:  shadow_cfg.dest_address = val;
            CFG_TX_OPTIONS:    shadow_cfg.tx_options = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input byte_t did, input byte_t cid,
                                  input logic [15:0] dest, input byte_t opts);
        write_reg(CFG_DATA_FRAME_ID, {8'h00, did});
        write_reg(CFG_CMD_FRAME_ID, {8'h00, cid});
        write_reg(CFG_DEST_ADDRESS, dest);
        write_reg(CFG_TX_OPTIONS, {8'h00, opts});
    endtask

    // drop valid and let every owed byte drain
    task automatic wait_idle;
        @(negedge clk);
        item_valid <= 1'b0;
        while (frame_bytes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // one complete frame; mid-frame words carry random junk in the ignored fields
    task automatic run_frame(input logic kind, input logic [LEN_W-1:0] len);
        in_t w;
        int  body;
        w = in_t'($urandom);
        w.mode = kind;
        w.payload_len = len;
        send_word(w);
        body = (len > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(len);
        for (int i = 1; i < body; i++)
            send_word(in_t'($urandom));
    endtask

    // receiver: checks every accepted byte against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            took_byte = 1'b1;
            if (frame_bytes.size() == 0)
                flag_mismatch($sformatf("unexpected byte %h at output %0d",
                                        result.out_byte, result_count));
            else
            begin
                out_t want;
                want = frame_bytes.pop_front();
                if (result.out_byte !== want.out_byte)
                    flag_mismatch($sformatf("output %0d out_byte got %h want %h",
                                            result_count, result.out_byte, want.out_byte));
                if (result.frame_done !== want.frame_done)
                    flag_mismatch($sformatf("output %0d frame_done got %b want %b",
                                            result_count, result.frame_done,
                                            want.frame_done));
                if (result.run_last !== want.run_last)
                    flag_mismatch($sformatf("output %0d run_last got %b want %b",
                                            result_count, result.run_last, want.run_last));
            end
            result_count = result_count + 1;
        end
    end

    // receiver back-pressure, a fresh hold-off after each byte taken
    always @(negedge clk)
    begin
        if (took_byte)
        begin
            took_byte = 1'b0;
            sink_wait = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (sink_wait > 0)
        begin
            result_stall <= 1'b1;
            sink_wait = sink_wait - 1;
        end
        else
            result_stall <= 1'b0;
    end

    // registers at their reset value of zero, both kinds, empty payload
    task automatic test_reset_values;
        send_word(make_word(MODE_DATA, 8'hA5, 7'd0, 8'h00, 8'h00));
        send_word(make_word(MODE_CMD, 8'hFF, 7'd0, 8'hFF, 8'hFF));
        wait_idle;
    endtask

    // short frames at extreme and then ordinary register settings, ignored mid-frame fields
    task automatic test_short_frames;
        write_all_regs(8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_word(make_word(MODE_DATA, 8'h00, 7'd0, 8'h00, 8'h00));
        send_word(make_word(MODE_CMD, 8'h00, 7'd0, 8'h00, 8'h00));
        send_word(make_word(MODE_DATA, 8'hFF, 7'd1, 8'h00, 8'h00));
        send_word(make_word(MODE_CMD, 8'h00, 7'd1, 8'hFF, 8'h00));
        // mode, length and command characters must be ignored mid-frame
        send_word(make_word(MODE_DATA, 8'h80, 7'd3, 8'h00, 8'h00));
        send_word(make_word(MODE_CMD, 8'h7F, 7'h7F, 8'hFF, 8'hFF));
        send_word(make_word(MODE_CMD, 8'h01, 7'd0, 8'hFF, 8'hFF));
        send_word(make_word(MODE_CMD, 8'hFE, 7'd2, 8'h00, 8'hFF));
        send_word(make_word(MODE_DATA, 8'h00, 7'd0, 8'h00, 8'h00));
        wait_idle;
        write_all_regs(8'h5A, 8'hA5, 16'h1234, 8'hC3);
        send_word(make_word(MODE_DATA, 8'h3C, 7'd2, 8'h11, 8'h22));
        send_word(make_word(MODE_DATA, 8'hC3, 7'd5, 8'h33, 8'h44));
        send_word(make_word(MODE_CMD, 8'h99, 7'd1, 8'h41, 8'h54));
        wait_idle;
    endtask

    // longest legal frame and a length that saturates to the maximum
    task automatic test_oversize_frames;
        run_frame(MODE_CMD, MAX_PAYLOAD);
        run_frame(MODE_DATA, 7'h7F);
        wait_idle;
    endtask

    // mostly short well-formed frames, a few long ones, several settings
    task automatic test_random_traffic;
        int               r;
        int               target;
        logic [LEN_W-1:0] len;
        for (int seg = 0; seg < 4; seg++)
        begin
            unique case (seg)
                1: write_all_regs(8'h00, 8'h00, 16'h0000, 8'h00);
                3: write_all_regs(byte_t'($urandom), byte_t'($urandom), 16'hFF00,
                                  byte_t'($urandom));
                default: write_all_regs(byte_t'($urandom), byte_t'($urandom),
                                        16'($urandom), byte_t'($urandom));
            endcase
            // one segment runs flat out on both sides
            gaps_on = (seg != 2);
            target = words_sent + 40;
            while (words_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = 7'd0;
                else if (r < 85)
                    len = LEN_W'($urandom_range(1, 6));
                else if (r < 97)
                    len = LEN_W'($urandom_range(7, 20));
                else
                    len = LEN_W'($urandom_range(64, 127));
                run_frame(logic'($urandom_range(0, 1)), len);
            end
            wait_idle;
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        shadow_cfg = '0;
        frame_open = 1'b0;
        open_kind = MODE_DATA;
        bytes_left = '0;
        csum = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values;
        test_short_frames;
        test_oversize_frames;
        test_random_traffic;

        wait_idle;
        repeat (20) @(posedge clk);
        if (frame_bytes.size() != 0)
            flag_mismatch($sformatf("%0d predicted bytes never came", frame_bytes.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hdl/afb_pkg.sv
hdl/afb_framer.sv
hdl/afb_serializer.sv
hdl/api_frame_builder_with_checksum.sv
test/tb.sv
